/* design/msis_pkg.sv */
// Shared types and constants for the media stream interleave scheduler.
// Holds the beat structs, the lane interface structs and the saturating adder.
// No dependencies.
package msis_pkg;

    localparam int NUM_SLOTS  = 4;
    localparam int TIME_W     = 64;
    localparam int TS_W       = 32;
    localparam int DUR_W      = 32;
    localparam int SIZE_W     = 32;
    localparam int OFF_W      = 32;
    localparam int CNT_W      = 32;
    localparam int START_W    = 63;
    localparam int CFG_DATA_W = 63;
    localparam int CFG_IDX_W  = 3;
    localparam int GRANT_W    = 2;
    localparam int LAST_W     = 3;

    localparam logic [LAST_W-1:0]    NONE_GRANTED       = 3'd4;
    localparam logic [TS_W-1:0]      TS_RESET           = 32'd90000;
    localparam logic [CFG_IDX_W-1:0] REG_TIMESCALE_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_BASE     = 3'd4;

    typedef struct packed {
        logic [3:0]        avail_mask;
        logic [DUR_W-1:0]  dur_s0;
        logic [DUR_W-1:0]  dur_s1;
        logic [DUR_W-1:0]  dur_s2;
        logic [DUR_W-1:0]  dur_s3;
        logic [SIZE_W-1:0] size_s0;
        logic [SIZE_W-1:0] size_s1;
        logic [SIZE_W-1:0] size_s2;
        logic [SIZE_W-1:0] size_s3;
    } in_beat_t;

    typedef struct packed {
        logic               found;
        logic [GRANT_W-1:0] grant;
        logic [OFF_W-1:0]   frame_offset;
        logic               new_run;
        logic [CNT_W-1:0]   run_count;
        logic               offset_overflow;
    } out_beat_t;

    typedef struct packed {
        logic                  ts_we;
        logic                  st_we;
        logic [CFG_DATA_W-1:0] data;
    } lane_cfg_t;

    typedef struct packed {
        logic              en;
        logic [DUR_W-1:0]  dur;
        logic [OFF_W-1:0]  end_off;
    } lane_upd_t;

    typedef struct packed {
        logic [TIME_W-1:0] plain;
        logic [TIME_W-1:0] biased;
    } lane_cand_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic found;
    } merge_stat_t;

    function automatic logic [TIME_W-1:0] sat_add64(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

/* design/msis_lane.sv */
// One stream lane: timescale, next decode time and run tracking of one stream.
// Produces the registered plain and biased candidate times for the merge stage.
// Depends on msis_pkg.
module msis_lane (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        is_last,
    input  logic                        snap,
    input  msis_pkg::lane_cfg_t         cfg,
    input  msis_pkg::lane_upd_t         upd,
    input  logic [msis_pkg::OFF_W-1:0]  offset,
    output msis_pkg::lane_cand_t        cand,
    output logic                        contiguous
);

    logic [msis_pkg::TS_W-1:0]   ts_reg;
    logic [msis_pkg::TIME_W-1:0] next_time_reg;
    logic [msis_pkg::OFF_W-1:0]  prev_end_reg;
    logic                        has_prev_reg;
    msis_pkg::lane_cand_t        cand_reg;
    msis_pkg::lane_cand_t        cand_next;
    logic [msis_pkg::TIME_W-1:0] bias;

    assign bias = msis_pkg::TIME_W'(ts_reg[msis_pkg::TS_W-1:2]);

    always_comb
    begin
        cand_next.plain  = next_time_reg;
        cand_next.biased = is_last ? next_time_reg
                                   : msis_pkg::sat_add64(next_time_reg, bias);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg        <= msis_pkg::TS_RESET;
            next_time_reg <= '0;
            prev_end_reg  <= '0;
            has_prev_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.ts_we)
            begin
                ts_reg <= cfg.data[msis_pkg::TS_W-1:0];
            end
            if (cfg.st_we)
            begin
                next_time_reg <= msis_pkg::TIME_W'(cfg.data);
            end
            else if (upd.en)
            begin
                next_time_reg <= msis_pkg::sat_add64(next_time_reg,
                                                     msis_pkg::TIME_W'(upd.dur));
            end
            if (upd.en)
            begin
                prev_end_reg <= upd.end_off;
                has_prev_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap)
        begin
            cand_reg <= cand_next;
        end
    end

    assign cand       = cand_reg;
    assign contiguous = has_prev_reg && (prev_end_reg == offset);

endmodule

/* design/msis_merge.sv */
// Merge stage: walks the lane candidates in index order, one compare per cycle,
// and keeps the running biased minimum and the selected lane.
// Depends on msis_pkg.
module msis_merge #(
    parameter int STREAMS = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   ack,
    input  logic [STREAMS-1:0]     mask,
    input  msis_pkg::lane_cand_t   cand [STREAMS],
    output msis_pkg::merge_stat_t  stat,
    output logic [(STREAMS > 1 ? $clog2(STREAMS) : 1)-1:0] sel
);

    localparam int IDX_W = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STREAMS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                      state_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [IDX_W-1:0]            sel_reg;
    logic                        any_reg;
    logic [msis_pkg::TIME_W-1:0] min_reg;
    logic                        take;

    assign take = mask[idx_reg] && (!any_reg || (cand[idx_reg].plain < min_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            sel_reg   <= '0;
            any_reg   <= 1'b0;
            min_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_SCAN;
                        idx_reg   <= '0;
                        sel_reg   <= '0;
                        any_reg   <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    if (take)
                    begin
                        any_reg <= 1'b1;
                        sel_reg <= idx_reg;
                        min_reg <= cand[idx_reg].biased;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (ack)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign stat.busy  = (state_reg == ST_SCAN);
    assign stat.done  = (state_reg == ST_DONE);
    assign stat.found = any_reg;
    assign sel        = sel_reg;

    a_sel_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done && stat.found |-> mask[sel_reg])
        else $error("Selected stream is not in the availability mask.");

    a_no_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.busy || stat.done) |-> !start)
        else $error("Scan started while a previous scan was in progress.");

endmodule

/* design/media_stream_interleave_scheduler_core.sv */
// Top level of the media stream interleave scheduler.
// Instantiates one msis_lane per stream and the msis_merge stage; uses msis_pkg.
//
// Usage: each beat on the item channel carries the availability mask and the
// duration and size of every stream's head frame. Each accepted item yields exactly
// one beat on the result channel: the granted stream, its payload offset, the run
// flag and counter, and the sticky offset overflow flag. With an empty mask the
// result reports that nothing was found and no state changes.
// An accepted item and the lane candidates are registered, then the merge stage
// compares one lane candidate per cycle in index order, and the result is registered.
// The next item is accepted only once the previous one has committed its result,
// so the serial walk over the lane candidates plus the commit sets the item rate.
// Configuration writes on cfg_we take effect at the next edge; a start time write
// also loads that stream's next decode time.
// Reset (rst_n, asynchronous, active low) restores timescales of 90000 ticks,
// zero times and offsets, and no previously granted stream.
// When the receiver stalls, the result register holds its beat; one further item
// may be accepted and scanned, and it commits once the held beat is taken.
module media_stream_interleave_scheduler_core #(
    parameter int STREAMS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  msis_pkg::in_beat_t                item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output msis_pkg::out_beat_t               result,
    input  logic                              cfg_we,
    input  logic [msis_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [msis_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IDX_W = (STREAMS > 1) ? $clog2(STREAMS) : 1;

    msis_pkg::in_beat_t           item_reg;
    logic                         pending_reg;
    logic                         result_valid_reg;
    msis_pkg::out_beat_t          result_reg;
    msis_pkg::out_beat_t          result_next;
    logic [msis_pkg::OFF_W-1:0]   running_offset_reg;
    logic [msis_pkg::CNT_W-1:0]   runs_opened_reg;
    logic                         overflow_seen_reg;
    logic [msis_pkg::LAST_W-1:0]  last_granted_reg;

    logic                         accept;
    logic                         commit;
    msis_pkg::merge_stat_t        stat;
    logic [IDX_W-1:0]             sel;
    logic [msis_pkg::GRANT_W-1:0] grant;
    msis_pkg::lane_cand_t         cand [STREAMS];
    logic [STREAMS-1:0]           cont;
    logic [msis_pkg::DUR_W-1:0]   dur_all  [msis_pkg::NUM_SLOTS];
    logic [msis_pkg::SIZE_W-1:0]  size_all [msis_pkg::NUM_SLOTS];
    logic [msis_pkg::OFF_W:0]     sum;
    logic                         new_run;

    assign accept = item_valid && item_ready;
    assign commit = stat.done && (!result_valid_reg || result_ready);
    assign grant  = msis_pkg::GRANT_W'(sel);

    assign dur_all[0]  = item_reg.dur_s0;
    assign dur_all[1]  = item_reg.dur_s1;
    assign dur_all[2]  = item_reg.dur_s2;
    assign dur_all[3]  = item_reg.dur_s3;
    assign size_all[0] = item_reg.size_s0;
    assign size_all[1] = item_reg.size_s1;
    assign size_all[2] = item_reg.size_s2;
    assign size_all[3] = item_reg.size_s3;

    assign sum     = {1'b0, running_offset_reg} + {1'b0, size_all[grant]};
    assign new_run = !cont[sel];

    genvar i;
    generate
        for (i = 0; i < STREAMS; i++)
        begin : g_lane
            msis_pkg::lane_cfg_t lane_cfg;
            msis_pkg::lane_upd_t lane_upd;

            always_comb
            begin
                lane_cfg.ts_we = cfg_we && (cfg_index ==
                    msis_pkg::CFG_IDX_W'(msis_pkg::REG_TIMESCALE_BASE + i));
                lane_cfg.st_we = cfg_we && (cfg_index ==
                    msis_pkg::CFG_IDX_W'(msis_pkg::REG_START_BASE + i));
                lane_cfg.data  = cfg_data;
                lane_upd.en      = commit && stat.found && (sel == IDX_W'(i));
                lane_upd.dur     = dur_all[i];
                lane_upd.end_off = sum[msis_pkg::OFF_W-1:0];
            end

            msis_lane u_lane (
                .clk        (clk),
                .rst_n      (rst_n),
                .is_last    (last_granted_reg == msis_pkg::LAST_W'(i)),
                .snap       (accept),
                .cfg        (lane_cfg),
                .upd        (lane_upd),
                .offset     (running_offset_reg),
                .cand       (cand[i]),
                .contiguous (cont[i])
            );
        end
    endgenerate

    msis_merge #(
        .STREAMS (STREAMS)
    ) u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .ack   (commit),
        .mask  (item_reg.avail_mask[STREAMS-1:0]),
        .cand  (cand),
        .stat  (stat),
        .sel   (sel)
    );

    always_comb
    begin
        result_next.found           = stat.found;
        result_next.grant           = '0;
        result_next.frame_offset    = '0;
        result_next.new_run         = 1'b0;
        result_next.run_count       = runs_opened_reg;
        result_next.offset_overflow = overflow_seen_reg;
        if (stat.found)
        begin
            result_next.grant           = grant;
            result_next.frame_offset    = running_offset_reg;
            result_next.new_run         = new_run;
            result_next.run_count       = runs_opened_reg + msis_pkg::CNT_W'(new_run);
            result_next.offset_overflow = overflow_seen_reg || sum[msis_pkg::OFF_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg        <= 1'b0;
            result_valid_reg   <= 1'b0;
            running_offset_reg <= '0;
            runs_opened_reg    <= '0;
            overflow_seen_reg  <= 1'b0;
            last_granted_reg   <= msis_pkg::NONE_GRANTED;
        end
        else
        begin
            if (accept)
            begin
                pending_reg <= 1'b1;
            end
            else if (commit)
            begin
                pending_reg <= 1'b0;
            end
            if (commit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            if (commit && stat.found)
            begin
                running_offset_reg <= sum[msis_pkg::OFF_W-1:0];
                runs_opened_reg    <= result_next.run_count;
                overflow_seen_reg  <= result_next.offset_overflow;
                last_granted_reg   <= msis_pkg::LAST_W'(sel);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (commit)
        begin
            result_reg <= result_next;
        end
    end

    assign item_ready   = !pending_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_pending_tracks_merge: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == (stat.busy || stat.done))
        else $error("Pending item and merge stage disagree.");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_seen_reg |=> overflow_seen_reg)
        else $error("Offset overflow flag cleared.");

    a_run_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        commit && stat.found && new_run |=>
            runs_opened_reg == $past(runs_opened_reg) + 1'b1)
        else $error("Run counter did not advance on a new run.");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.found |->
            result_reg.grant == '0 && result_reg.frame_offset == '0 &&
            !result_reg.new_run)
        else $error("Empty result carries grant fields.");

endmodule
